// File: rtl/xyl_pkg.sv
// Package: shared constants, types and trig functions for the lattice spin engine.
`default_nettype none
package xyl_pkg;
  localparam int MAX_SIDE_DEF = 32;
  localparam int ANGLE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_PROPOSE = 2'd0,
    OP_APPLY   = 2'd1,
    OP_MEASURE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [7:0] REG_SIDE = 8'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROP,
    ST_PWAIT,
    ST_APPLY_RD,
    ST_APPLY_WR,
    ST_MEAS,
    ST_MWAIT,
    ST_SQ,
    ST_DONE
  } state_t;

  // Result payload.
  typedef struct packed {
    logic signed [18:0] energy_delta;
    logic signed [26:0] total_energy;
    logic [48:0]        sin_sum_squared;
    logic [9:0]         pos_vortices;
    logic [9:0]         neg_vortices;
  } result_t;

  // Sine of step k of 128 in Q1.14 from the quarter-wave table.
  function automatic logic [14:0] qsine(input logic [5:0] j);
    logic [14:0] v;
    begin
      case (j)
        6'd0: v = 15'd0;      6'd1: v = 15'd804;    6'd2: v = 15'd1606;
        6'd3: v = 15'd2404;   6'd4: v = 15'd3196;   6'd5: v = 15'd3981;
        6'd6: v = 15'd4756;   6'd7: v = 15'd5520;   6'd8: v = 15'd6270;
        6'd9: v = 15'd7005;   6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
        6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
        6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
        6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
        6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
        6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
        6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
        6'd30: v = 15'd16305; 6'd31: v = 15'd16364; default: v = 15'd16384;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [15:0] step_sin(input logic [6:0] idx);
    logic [4:0] j;
    begin
      j = idx[4:0];
      case (idx[6:5])
        2'd0: return $signed({1'b0, qsine({1'b0, j})});
        2'd1: return $signed({1'b0, qsine(6'd32 - {1'b0, j})});
        2'd2: return -$signed({1'b0, qsine({1'b0, j})});
        default: return -$signed({1'b0, qsine(6'd32 - {1'b0, j})});
      endcase
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/xyl_if.sv
// Interfaces: valid/ready request channels for items and results.
`default_nettype none
interface xyl_item_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [9:0] site;
  logic [15:0] angle;
  modport source(output valid, op, site, angle, input ready);
  modport sink(input valid, op, site, angle, output ready);
endinterface

interface xyl_result_if import xyl_pkg::*;;
  logic valid;
  logic ready;
  logic signed [18:0] energy_delta;
  logic signed [26:0] total_energy;
  logic [48:0] sin_sum_squared;
  logic [9:0] pos_vortices;
  logic [9:0] neg_vortices;
  modport source(output valid, energy_delta, total_energy, sin_sum_squared,
                 pos_vortices, neg_vortices, input ready);
  modport sink(input valid, energy_delta, total_energy, sin_sum_squared,
               pos_vortices, neg_vortices, output ready);
endinterface
`default_nettype wire

// File: rtl/xyl_store.sv
// Angle store: synchronous RAM with one write port, one registered read port and a clearing pass.
`default_nettype none
module xyl_store import xyl_pkg::*; #(
  parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [ANGLE_BITS-1:0] rd_data,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [ANGLE_BITS-1:0] wr_data,
  output logic                       clear_busy
);
  logic [ANGLE_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]         clr_addr;
  logic                  clearing;

  // After reset every entry is written with zero, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= '0;
    else if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign clear_busy = clearing;
endmodule
`default_nettype wire

// File: rtl/xy_lattice_spin_engine_unit.sv
// Top level: lattice spin engine with APB side register, sequencer and angle store.
//  channel | dir | handshake    | payload
//  items   | in  | valid/ready  | op, site, angle
//  results | out | valid/ready  | energy_delta, total_energy, sin_sum_squared, vortices
//  apb     | in  | psel/penable | lattice_side
// After reset the store clears every entry with ready held low.
// Propose: q = site / n (up to 511 at side two) is found by one compare-subtract per
// cycle, then the site and its four neighbours are read.
// Apply: row search, then a read and a write of the site. Measure: a pass over every site.
// The next request can be accepted in the cycle after the result is registered.
// A stalled result waits in the output register while the next request is computed; that
// request then holds in its last state until the register frees.
`default_nettype none
module xy_lattice_spin_engine_unit import xyl_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  xyl_item_if.sink         in_ch,
  xyl_result_if.source     out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int STEP_SHIFT = ANGLE_BITS - 7;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  logic [5:0] lattice_side;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_SIDE[1:0]) ? {26'd0, lattice_side} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) lattice_side <= 6'd32;
    else if (psel && penable && pwrite && paddr == REG_SIDE[1:0]) lattice_side <= pwdata[5:0];
  end

  logic [SW-1:0] n;
  always_comb begin
    if (lattice_side < 6'd2) n = SW'(2);
    else if (32'(lattice_side) > MAX_SIDE) n = SW'(MAX_SIDE);
    else n = SW'(lattice_side);
  end

  function automatic logic signed [15:0] tcos(input logic [ANGLE_BITS-1:0] p);
    logic [ANGLE_BITS-1:0] q;
    logic [ANGLE_BITS:0] r;
    begin
      q = p + QUARTER;
      r = {1'b0, q} + ((ANGLE_BITS+1)'(1) << (STEP_SHIFT - 1));
      return step_sin(r[STEP_SHIFT +: 7]);
    end
  endfunction
  function automatic logic signed [15:0] tsin(input logic [ANGLE_BITS-1:0] p);
    logic [ANGLE_BITS:0] r;
    begin
      r = {1'b0, p} + ((ANGLE_BITS+1)'(1) << (STEP_SHIFT - 1));
      return step_sin(r[STEP_SHIFT +: 7]);
    end
  endfunction
  function automatic logic signed [2:0] wsign(input logic [ANGLE_BITS-1:0] a,
                                               input logic [ANGLE_BITS-1:0] b);
    logic [ANGLE_BITS-1:0] d;
    begin
      d = a - b;
      return (d >= HALF) ? -3'sd1 : 3'sd0;
    end
  endfunction

  // Store.
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [ANGLE_BITS-1:0] rd_data, wr_data;
  logic clear_busy;
  xyl_store #(.DEPTH(DEPTH), .ANGLE_BITS(ANGLE_BITS)) u_store (
    .clk, .rst, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data, .clear_busy
  );

  state_t state, state_next;
  logic [1:0] op;
  logic [ANGLE_BITS-1:0] ang;
  logic [AW:0] rem;           // site remainder during row search
  logic [SW-1:0] row, col, r, c;
  logic [3:0] k;              // read slot counter
  logic [ANGLE_BITS-1:0] a0, a1, a2, a3;
  logic signed [20:0] psum;
  logic signed [27:0] esum;
  logic signed [24:0] ssum;
  logic [9:0] pos, neg;
  logic [24:0] mag;
  logic [49:0] sq;
  result_t res;
  result_t hold;
  logic out_valid;

  // Address of (row, col); the wrap is done by inc and dec.
  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] rr, input logic [SW-1:0] cc,
                                           input logic [SW-1:0] nn);
    logic [2*SW-1:0] p;
    begin
      p = rr * nn;
      return AW'(p + (2*SW)'(cc));
    end
  endfunction
  function automatic logic [SW-1:0] inc(input logic [SW-1:0] x, input logic [SW-1:0] nn);
    return (x + SW'(1) == nn) ? '0 : x + SW'(1);
  endfunction
  function automatic logic [SW-1:0] dec(input logic [SW-1:0] x, input logic [SW-1:0] nn);
    return (x == '0) ? nn - SW'(1) : x - SW'(1);
  endfunction

  assign in_ch.ready = (state == ST_IDLE) && !clear_busy;
  wire in_acc = in_ch.valid && in_ch.ready;
  wire res_take = (state == ST_DONE) && (!out_valid || out_ch.ready);

  // Read address per slot.
  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    if (state == ST_PROP || (state == ST_APPLY_RD)) begin
      rd_en = 1'b1;
      case (k)
        4'd0: rd_addr = addr_of(row, col, n);
        4'd1: rd_addr = addr_of(inc(row, n), col, n);
        4'd2: rd_addr = addr_of(row, inc(col, n), n);
        4'd3: rd_addr = addr_of(dec(row, n), col, n);
        default: rd_addr = addr_of(row, dec(col, n), n);
      endcase
    end else if (state == ST_MEAS) begin
      rd_en = 1'b1;
      case (k)
        4'd0: rd_addr = addr_of(r, c, n);
        4'd1: rd_addr = addr_of(r, inc(c, n), n);
        4'd2: rd_addr = addr_of(inc(r, n), c, n);
        default: rd_addr = addr_of(inc(r, n), inc(c, n), n);
      endcase
    end
  end

  assign wr_en = (state == ST_APPLY_WR);
  assign wr_addr = addr_of(row, col, n);
  assign wr_data = a0 + ang;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  wire last_k_prop = (k == 4'd5);
  wire last_k_meas = (k == 4'd4);
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.op)
            OP_PROPOSE, OP_APPLY: state_next = ST_DIV;
            OP_MEASURE:           state_next = ST_MEAS;
            default:              state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        if (rem < (AW+1)'(n)) begin
          if (op == OP_PROPOSE) state_next = ST_PROP;
          else state_next = ST_APPLY_RD;
        end
      end
      ST_PROP:     if (last_k_prop) state_next = ST_PWAIT;
      ST_PWAIT:    state_next = ST_DONE;
      ST_APPLY_RD: if (k == 4'd1) state_next = ST_APPLY_WR;
      ST_APPLY_WR: state_next = ST_DONE;
      ST_MEAS: begin
        if (last_k_meas && r == n - SW'(1) && c == n - SW'(1)) state_next = ST_MWAIT;
      end
      ST_MWAIT:    state_next = ST_SQ;
      ST_SQ:       state_next = ST_DONE;
      ST_DONE:     if (res_take) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Datapath. Read data for slot k-1 arrives while k is issued.
  logic signed [15:0] c_new, c_old;
  logic [ANGLE_BITS-1:0] dold;
  always_comb begin
    dold = a0 - rd_data;
    c_new = tcos(dold + ang);
    c_old = tcos(dold);
  end
  logic signed [2:0] wsum;
  always_comb begin
    wsum = wsign(a1, a0) + wsign(a3, a1) + wsign(a2, a3) + wsign(a0, a2);
  end
  logic signed [ANGLE_BITS+2:0] wtot;
  always_comb begin
    wtot = $signed({3'b0, ANGLE_BITS'(a1 - a0)}) + $signed({3'b0, ANGLE_BITS'(a3 - a1)})
         + $signed({3'b0, ANGLE_BITS'(a2 - a3)}) + $signed({3'b0, ANGLE_BITS'(a0 - a2)})
         + ($signed({{(ANGLE_BITS-0){wsum[2]}}, wsum}) <<< ANGLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            op <= in_ch.op;
            ang <= in_ch.angle[ANGLE_BITS-1:0];
          end
          rem <= (AW+1)'(in_ch.site);
          row <= '0;
          k <= '0;
          psum <= '0;
          esum <= '0;
          ssum <= '0;
          r <= '0;
          c <= '0;
        end
        ST_DIV: begin
          if (rem >= (AW+1)'(n)) begin
            rem <= rem - (AW+1)'(n);
            row <= inc(row, n);
          end else begin
            col <= SW'(rem);
          end
        end
        ST_PROP, ST_APPLY_RD: begin
          k <= k + 4'd1;
          if (k == 4'd1) a0 <= rd_data;
          if (k >= 4'd2) psum <= psum + 21'(c_old) - 21'(c_new);
        end
        ST_PWAIT: ;
        ST_APPLY_WR: ;
        ST_MEAS: begin
          k <= last_k_meas ? 4'd0 : k + 4'd1;
          case (k)
            4'd1: a0 <= rd_data;
            4'd2: a1 <= rd_data;
            4'd3: a2 <= rd_data;
            4'd4: a3 <= rd_data;
            default: ;
          endcase
          if (k == 4'd4) begin
            if (c == n - SW'(1)) begin
              c <= '0;
              r <= r + SW'(1);
            end else begin
              c <= c + SW'(1);
            end
          end
          // The previous site's bonds are added while a0 still holds that site.
          if (k == 4'd1 && !(r == '0 && c == '0)) begin
            esum <= esum + 28'(tcos(a1 - a0)) + 28'(tcos(a2 - a0));
            ssum <= ssum + 25'(tsin(a1 - a0));
          end
        end
        ST_MWAIT: begin
          esum <= esum + 28'(tcos(a1 - a0)) + 28'(tcos(a2 - a0));
          ssum <= ssum + 25'(tsin(a1 - a0));
        end
        ST_SQ: ;
        default: ;
      endcase
    end
  end

  // Vortex check on the previous site's corners, captured when its four reads finish.
  logic vchk;
  logic [SW-1:0] vr, vc;
  always_ff @(posedge clk) begin
    if (rst) vchk <= 1'b0;
    else vchk <= (state == ST_MEAS && k == 4'd4);
    if (state == ST_MEAS && k == 4'd4) begin
      vr <= r;
      vc <= c;
    end
    if (state == ST_IDLE) begin
      pos <= '0;
      neg <= '0;
    end else if (vchk && vr != n - SW'(1) && vc != n - SW'(1)) begin
      if (wtot > 0) pos <= pos + 10'd1;
      else if (wtot < 0) neg <= neg + 10'd1;
    end
  end

  assign mag = ssum[24] ? 25'(-ssum) : 25'(ssum);
  always_ff @(posedge clk) begin
    if (state == ST_SQ) sq <= 50'(mag) * 50'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_take) out_valid <= 1'b1;
    else if (out_valid && out_ch.ready) out_valid <= 1'b0;
  end
  always_comb begin
    res = '0;
    if (op == OP_PROPOSE) res.energy_delta = 19'(psum);
    if (op == OP_MEASURE) begin
      res.total_energy = 27'(-esum);
      res.sin_sum_squared = sq[48:0];
      res.pos_vortices = pos;
      res.neg_vortices = neg;
    end
  end
  always_ff @(posedge clk) begin
    if (res_take) hold <= res;
  end
  assign out_ch.valid = out_valid;
  assign out_ch.energy_delta = hold.energy_delta;
  assign out_ch.total_energy = hold.total_energy;
  assign out_ch.sin_sum_squared = hold.sin_sum_squared;
  assign out_ch.pos_vortices = hold.pos_vortices;
  assign out_ch.neg_vortices = hold.neg_vortices;

  assert property (@(posedge clk) disable iff (rst) in_acc |=> state != ST_IDLE)
    else $error("accepted request did not start work");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ch.ready |=> out_valid && $stable(hold))
    else $error("pending result dropped or changed");
  assert property (@(posedge clk) disable iff (rst) wr_en |-> op == OP_APPLY)
    else $error("store write outside apply");
  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> !clear_busy)
    else $error("ready while store is clearing");
endmodule
`default_nettype wire
